// File: rtl/bak_pkg.sv
// Shared constants and helper functions for the BAKSHEESH encryption pipeline.
`default_nettype none
package bak_pkg;

  localparam int BLOCK_W     = 128;
  localparam int ROUND_LIMIT = 35;
  localparam int RCON_W      = 6;
  localparam int NUM_TAPS    = 6;

  // Configuration register indexes (byte address = 8 * index)
  localparam logic [1:0] REG_KEY_HIGH    = 2'd0;
  localparam logic [1:0] REG_KEY_LOW     = 2'd1;
  localparam logic [1:0] REG_ROUND_COUNT = 2'd2;

  localparam logic [5:0] ROUND_COUNT_RESET = 6'd35;

  localparam logic [3:0] SBOX [16] = '{
    4'd3, 4'd0, 4'd6, 4'd13, 4'd11, 4'd5, 4'd8, 4'd14,
    4'd12, 4'd15, 4'd9, 4'd2, 4'd4, 4'd10, 4'd7, 4'd1
  };

  localparam logic [6:0] PERM_ROW [16] = '{
    7'd0, 7'd33, 7'd66, 7'd99, 7'd96, 7'd1, 7'd34, 7'd67,
    7'd64, 7'd97, 7'd2, 7'd35, 7'd32, 7'd65, 7'd98, 7'd3
  };

  localparam logic [6:0] TAP_POS [NUM_TAPS] = '{
    7'd8, 7'd13, 7'd19, 7'd35, 7'd67, 7'd106
  };

  localparam logic [RCON_W-1:0] ROUND_CONST [ROUND_LIMIT] = '{
    6'd2, 6'd33, 6'd16, 6'd9, 6'd36, 6'd19, 6'd40, 6'd53,
    6'd26, 6'd13, 6'd38, 6'd51, 6'd56, 6'd61, 6'd62, 6'd31,
    6'd14, 6'd7, 6'd34, 6'd49, 6'd24, 6'd45, 6'd54, 6'd59,
    6'd28, 6'd47, 6'd22, 6'd43, 6'd20, 6'd11, 6'd4, 6'd3,
    6'd32, 6'd17, 6'd8
  };

  // Destination bit of source bit i under the bit permutation
  function automatic logic [6:0] perm_dest(input int i);
    logic [6:0] row;
    logic [6:0] col;
    row = PERM_ROW[i & 15];
    col = 7'((i >> 4) << 2);
    return row + col;
  endfunction

endpackage
`default_nettype wire

// File: rtl/bak_round.sv
// One BAKSHEESH round: S-box layer, bit permutation, constant taps, round key.
`default_nettype none
module bak_round
  import bak_pkg::*;
(
  input  wire logic [BLOCK_W-1:0] st_in,
  input  wire logic [BLOCK_W-1:0] rkey,
  input  wire logic [RCON_W-1:0]  rcon,
  input  wire logic               active,
  output logic      [BLOCK_W-1:0] st_out
);

  logic [BLOCK_W-1:0] sub;
  logic [BLOCK_W-1:0] perm;
  logic [BLOCK_W-1:0] with_rc;

  for (genvar n = 0; n < BLOCK_W / 4; n++) begin : g_sbox
    assign sub[4*n +: 4] = SBOX[st_in[4*n +: 4]];
  end

  for (genvar i = 0; i < BLOCK_W; i++) begin : g_perm
    assign perm[perm_dest(i)] = sub[i];
  end

  always_comb begin
    with_rc = perm;
    for (int t = 0; t < NUM_TAPS; t++) begin
      with_rc[TAP_POS[t]] = with_rc[TAP_POS[t]] ^ rcon[t];
    end
  end

  // Rounds past the configured count pass the state through untouched
  assign st_out = active ? (with_rc ^ rkey) : st_in;

endmodule
`default_nettype wire

// File: rtl/baksheesh_block_encrypt_top.sv
// Top level of the BAKSHEESH block encryption pipeline with its register port.
//
// Encrypts one 128-bit block per clock unless out_stall holds the pipeline. The
// pipeline has one whitening stage and one stage per round (35); a request passes
// through them in order. Rounds beyond round_count pass the block through, so its
// path does not depend on the round count; counts above 35 act as 35. When a finished
// block waits on out_stall, the whole pipeline holds and in_stall rises with it.
// Registers: key_high at 0x00, key_low at 0x08, round_count at 0x10 (reset 35).
// Write them only while no request is in flight.
`default_nettype none
module baksheesh_block_encrypt_top
  import bak_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [63:0] pwdata,
  output logic      [63:0] prdata,
  output logic             pready,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [63:0] pt_high,
  input  wire logic [63:0] pt_low,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic      [63:0] ct_high,
  output logic      [63:0] ct_low
);

  localparam int NSTAGE = ROUND_LIMIT + 1;

  logic [63:0] key_high;
  logic [63:0] key_low;
  logic [5:0]  round_count;
  logic [1:0]  reg_idx;
  logic        reg_wr;

  logic [BLOCK_W-1:0] key;
  logic [NSTAGE-1:0]  vld;
  logic [BLOCK_W-1:0] st [NSTAGE];
  logic [BLOCK_W-1:0] rnd_out [NSTAGE];
  logic               advance;
  logic               in_acc;

  // Register port
  assign pready  = 1'b1;
  assign reg_idx = paddr[4:3];
  assign reg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      key_high    <= '0;
      key_low     <= '0;
      round_count <= ROUND_COUNT_RESET;
    end else if (reg_wr) begin
      case (reg_idx)
        REG_KEY_HIGH:    key_high    <= pwdata;
        REG_KEY_LOW:     key_low     <= pwdata;
        REG_ROUND_COUNT: round_count <= pwdata[5:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_KEY_HIGH:    prdata = key_high;
      REG_KEY_LOW:     prdata = key_low;
      REG_ROUND_COUNT: prdata = {58'd0, round_count};
      default:         prdata = '0;
    endcase
  end

  assign key = {key_high, key_low};

  // Hold everything while the finished block waits
  assign advance  = !(vld[NSTAGE-1] && out_stall);
  assign in_stall = !advance;
  assign in_acc   = in_valid && advance;

  assign rnd_out[0] = {pt_high, pt_low} ^ key;

  for (genvar r = 1; r < NSTAGE; r++) begin : g_round
    logic [BLOCK_W-1:0] rkey;
    logic               active;
    // round r uses the master key rotated right by r
    assign rkey   = {key[r-1:0], key[BLOCK_W-1:r]};
    assign active = round_count >= 6'(r);
    bak_round u_round (
      .st_in  (st[r-1]),
      .rkey   (rkey),
      .rcon   (ROUND_CONST[r-1]),
      .active (active),
      .st_out (rnd_out[r])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (advance) begin
      vld <= {vld[NSTAGE-2:0], in_acc};
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      for (int s = 0; s < NSTAGE; s++) begin
        st[s] <= rnd_out[s];
      end
    end
  end

  assign out_valid = vld[NSTAGE-1];
  assign ct_high   = st[NSTAGE-1][127:64];
  assign ct_low    = st[NSTAGE-1][63:0];

  a_enter: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> vld[0])
    else $error("accepted request did not enter the first stage");

  a_reach_out: assert property (@(posedge clk) disable iff (rst)
    advance && vld[NSTAGE-2] |=> out_valid)
    else $error("request lost on the way to the output");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    !advance |=> $stable(vld) && $stable(st[NSTAGE-1]))
    else $error("pipeline moved while the output was stalled");

  a_zero_rounds: assert property (@(posedge clk) disable iff (rst)
    advance && vld[NSTAGE-2] && round_count == 6'd0 && $stable(round_count)
      |=> {ct_high, ct_low} == $past(st[NSTAGE-2]))
    else $error("zero round count changed the whitened block");

endmodule
`default_nettype wire

// File: dv/baksheesh_block_encrypt_checker.sv
// Channel monitor, ciphertext predictor and scoreboard for the BAKSHEESH encryption block.
`timescale 1ns / 100ps
module baksheesh_block_encrypt_checker
  import bak_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic        pready,
  input  logic [4:0]  paddr,
  input  logic [63:0] pwdata,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [63:0] pt_high,
  input  logic [63:0] pt_low,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [63:0] ct_high,
  input  logic [63:0] ct_low,
  output int          fail_count,
  output int          outstanding
);

  localparam int MAX_ROUND_COUNT = 35;

  // Packed lookup tables, entry n at the low end: S-box by nibble, permutation
  // row by byte, tap positions by byte, round constants by byte.
  localparam logic [63:0]  NIBBLE_SUB   = 64'h17A4_29FC_E85B_D603;
  localparam logic [127:0] BIT_DEST_ROW = 128'h03624120_23026140_43220160_63422100;
  localparam logic [47:0]  TAP_BITS     = 48'h6A43_2313_0D08;
  localparam logic [279:0] ROUND_CONST_SEQ =
    280'h0811200304_0B142B162F_1C3B362D18_3122070E1F_3E3D383326_0D1A352813_2409102102;

  typedef struct packed {
    logic [63:0] hi;
    logic [63:0] lo;
  } cipher_block_t;

  logic [127:0]  key_mirror;
  logic [5:0]    rounds_mirror;
  cipher_block_t ct_expect_q[$];

  function automatic logic [127:0] baksheesh_encrypt(input logic [127:0] pt,
                                                     input logic [127:0] mkey,
                                                     input logic [5:0]   nrounds);
    logic [127:0] st;
    logic [127:0] rk;
    logic [127:0] moved;
    int           last;
    int           dest;
    last = (nrounds > 6'd35) ? MAX_ROUND_COUNT : int'(nrounds);
    st = pt ^ mkey;
    rk = mkey;
    for (int r = 0; r < last; r++) begin
      // rotate the whole 128-bit key right by one
      rk = {rk[0], rk[127:1]};
      for (int n = 0; n < 32; n++) begin
        st[4*n +: 4] = NIBBLE_SUB[4*st[4*n +: 4] +: 4];
      end
      moved = '0;
      for (int i = 0; i < 128; i++) begin
        dest = (int'(BIT_DEST_ROW[8*(i%16) +: 8]) + 4*(i/16)) % 128;
        moved[dest] = st[i];
      end
      st = moved;
      for (int t = 0; t < 6; t++) begin
        if (ROUND_CONST_SEQ[8*r + t]) begin
          st[TAP_BITS[8*t +: 8]] = ~st[TAP_BITS[8*t +: 8]];
        end
      end
      st = st ^ rk;
    end
    return st;
  endfunction

  always @(posedge clk) begin : monitor
    cipher_block_t got;
    cipher_block_t want;
    if (rst) begin
      key_mirror    <= '0;
      rounds_mirror <= ROUND_COUNT_RESET;
      ct_expect_q.delete();
      fail_count    <= 0;
      outstanding   <= 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[4:3])
          REG_KEY_HIGH:    key_mirror[127:64] <= pwdata;
          REG_KEY_LOW:     key_mirror[63:0]   <= pwdata;
          REG_ROUND_COUNT: rounds_mirror      <= pwdata[5:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        ct_expect_q.push_back(baksheesh_encrypt({pt_high, pt_low}, key_mirror, rounds_mirror));
      end
      if (out_valid && !out_stall) begin
        got = {ct_high, ct_low};
        if (ct_expect_q.size() == 0) begin
          $display("%0t: unexpected ciphertext, expected none, got %h %h", $time,
                   got.hi, got.lo);
          fail_count <= fail_count + 1;
        end else begin
          want = ct_expect_q.pop_front();
          if (want.hi !== got.hi) begin
            $display("%0t: ct_high expected %h got %h", $time, want.hi, got.hi);
          end
          if (want.lo !== got.lo) begin
            $display("%0t: ct_low expected %h got %h", $time, want.lo, got.lo);
          end
          if (want !== got) begin
            fail_count <= fail_count + 1;
          end
        end
      end
      outstanding <= ct_expect_q.size();
    end
  end

endmodule

// File: dv/baksheesh_block_encrypt_top_tb.sv
// Stimulus, register programming and verdict for the BAKSHEESH encryption block.
`timescale 1ns / 100ps
module baksheesh_block_encrypt_top_tb
  import bak_pkg::*;
;

  localparam logic [1:0]  REG_SPARE   = 2'd3;
  localparam logic [63:0] ALL_ONES    = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam int          STALL_LIMIT = 2000;
  localparam int          DRAIN_WAIT  = 40;
  localparam int          SEGMENTS    = 10;
  localparam int          SEG_BLOCKS  = 200;

  logic        clk = 1'b0;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [4:0]  paddr;
  logic [63:0] pwdata;
  logic [63:0] prdata;
  logic        pready;
  logic        in_valid;
  logic        in_stall;
  logic [63:0] pt_high;
  logic [63:0] pt_low;
  logic        out_valid;
  logic        out_stall;
  logic [63:0] ct_high;
  logic [63:0] ct_low;

  int mismatch_count;
  int blocks_pending;
  int tx_idle_pct = 25;
  int rx_idle_pct = 74;
  int quiet_cycles;

  baksheesh_block_encrypt_top uut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_stall(in_stall), .pt_high(pt_high), .pt_low(pt_low),
    .out_valid(out_valid), .out_stall(out_stall), .ct_high(ct_high), .ct_low(ct_low)
  );

  baksheesh_block_encrypt_checker checker_i (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
    .paddr(paddr), .pwdata(pwdata),
    .in_valid(in_valid), .in_stall(in_stall), .pt_high(pt_high), .pt_low(pt_low),
    .out_valid(out_valid), .out_stall(out_stall), .ct_high(ct_high), .ct_low(ct_low),
    .fail_count(mismatch_count), .outstanding(blocks_pending)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < rx_idle_pct);
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("baksheesh_block_encrypt_top_tb failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Mostly random words, with the odd all-zero or all-one word.
  function automatic logic [63:0] rand_word();
    case ($urandom_range(15))
      0:       return '0;
      1:       return ALL_ONES;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  task automatic write_reg(input logic [1:0] idx, input logic [63:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic send_block(input logic [63:0] hi, input logic [63:0] lo);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    pt_high  <= hi;
    pt_low   <= lo;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Drop valid and wait until every ciphertext has come back.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (blocks_pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic load_config(input logic [63:0] khi, input logic [63:0] klo,
                             input logic [5:0] rounds);
    write_reg(REG_KEY_HIGH, khi);
    write_reg(REG_KEY_LOW, klo);
    write_reg(REG_ROUND_COUNT, {58'd0, rounds});
  endtask

  initial begin
    logic [5:0] rounds;
    rst       <= 1'b1;
    psel      <= 1'b0;
    penable   <= 1'b0;
    pwrite    <= 1'b0;
    paddr     <= '0;
    pwdata    <= '0;
    in_valid  <= 1'b0;
    pt_high   <= '0;
    pt_low    <= '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset configuration: zero key, full rounds.
    send_block('0, '0);
    send_block(ALL_ONES, ALL_ONES);
    send_block(64'hAAAA_AAAA_AAAA_AAAA, 64'hAAAA_AAAA_AAAA_AAAA);
    send_block(64'h5555_5555_5555_5555, 64'h5555_5555_5555_5555);
    send_block('0, 64'd1);
    send_block(64'h8000_0000_0000_0000, '0);
    drain();

    // Zero rounds: whitening only.
    load_config(ALL_ONES, ALL_ONES, 6'd0);
    send_block('0, '0);
    send_block(64'h0123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_3210);
    send_block(ALL_ONES, ALL_ONES);
    drain();

    load_config(64'h0123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_3210, 6'd1);
    send_block('0, '0);
    send_block(ALL_ONES, '0);
    drain();

    // Counts above the maximum saturate.
    write_reg(REG_ROUND_COUNT, 64'd63);
    send_block(64'hDEAD_BEEF_0000_FFFF, 64'h1234_5678_9ABC_DEF0);
    send_block('0, ALL_ONES);
    drain();
    write_reg(REG_ROUND_COUNT, 64'd36);
    send_block(64'hDEAD_BEEF_0000_FFFF, 64'h1234_5678_9ABC_DEF0);
    drain();

    // A write past the last register must leave the configuration alone.
    write_reg(REG_SPARE, ALL_ONES);
    send_block(64'hDEAD_BEEF_0000_FFFF, 64'h1234_5678_9ABC_DEF0);
    drain();

    for (int seg = 0; seg < SEGMENTS; seg++) begin
      if (seg < 4) begin
        tx_idle_pct = 25;
        rx_idle_pct = 74;
      end else if (seg < 7) begin
        tx_idle_pct = 74;
        rx_idle_pct = 25;
      end else begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      case (seg % 5)
        0:       rounds = 6'd35;
        1:       rounds = 6'd0;
        2:       rounds = 6'd63;
        3:       rounds = 6'($urandom_range(1, 34));
        default: rounds = 6'($urandom_range(36, 62));
      endcase
      if (seg == 1) begin
        load_config('0, '0, rounds);
      end else if (seg == 2) begin
        load_config(ALL_ONES, ALL_ONES, rounds);
      end else begin
        load_config(rand_word(), rand_word(), rounds);
      end
      for (int n = 0; n < SEG_BLOCKS; n++) begin
        send_block(rand_word(), rand_word());
      end
      drain();
    end

    repeat (DRAIN_WAIT) @(posedge clk);
    if (mismatch_count == 0 && blocks_pending == 0) begin
      $display("baksheesh_block_encrypt_top_tb passed");
    end else begin
      $display("baksheesh_block_encrypt_top_tb failed");
    end
    $finish;
  end

endmodule

// File: baksheesh_block_encrypt_top.f
rtl/bak_pkg.sv
rtl/bak_round.sv
rtl/baksheesh_block_encrypt_top.sv
dv/baksheesh_block_encrypt_checker.sv
dv/baksheesh_block_encrypt_top_tb.sv
